// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- sv/ohl_pkg.sv -----
// ----------------------------------------------------------------------------
// ohl_pkg
// Types, codes and default sizes shared by the ordered handle list.
// ----------------------------------------------------------------------------
package ohl_pkg;

	// Default sizes for the top-level parameters.
	localparam int CAPACITY_DEF     = 16;
	localparam int HANDLE_WIDTH_DEF = 32;

	// Request opcodes.
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_GET    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_FIND   = 2'd3;

	// Response status codes.
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_INVALID  = 2'd1;
	localparam logic [1:0] STS_NOTFOUND = 2'd2;
	localparam logic [1:0] STS_FULL     = 2'd3;

	// One request.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] handle;
		logic [31:0] position;
	} req_t;

	// One response.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_handle;
		logic [3:0]  found_position;
		logic [4:0]  entry_count;
	} rsp_t;

endpackage

// ----- sv/ohl_ram.sv -----
// ----------------------------------------------------------------------------
// ohl_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ohl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/ohl_seq.sv -----
// ----------------------------------------------------------------------------
// ohl_seq
// Request sequencer: decodes one request, scans and compacts the entry RAM
// one entry per cycle, and keeps the fill count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ohl_seq #(
	parameter int CAPACITY     = ohl_pkg::CAPACITY_DEF,
	parameter int HANDLE_WIDTH = ohl_pkg::HANDLE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  ohl_pkg::req_t               req,
	output logic                        idle,
	output logic                        done,
	input  logic                        take,
	output ohl_pkg::rsp_t               rsp,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [HANDLE_WIDTH-1:0]     mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [HANDLE_WIDTH-1:0]     mem_rdata
);

	import ohl_pkg::*;

	localparam int IW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int CW1 = CW + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_GETW  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;
	localparam logic [2:0] ST_RESP  = 3'd5;

	logic [2:0]              state_q, state_d;
	logic [CW-1:0]           count_q, count_d;
	logic [1:0]              op_q;
	logic [HANDLE_WIDTH-1:0] hnd_q;
	logic [31:0]             pos_q;
	logic [IW-1:0]           idx_q, idx_d;
	logic [1:0]              status_q, status_d;
	logic [HANDLE_WIDTH-1:0] got_q, got_d;
	logic [IW-1:0]           where_q, where_d;

	logic [63:0]  hnd_wide;
	logic [63:0]  got_wide;
	logic [63:0]  where_wide;
	logic [63:0]  count_wide;
	logic [CW1-1:0] count_ext;
	logic [CW1-1:0] nxt1;
	logic [CW1-1:0] nxt2;
	logic         null_h;
	logic         full;
	logic         pos_ok;
	logic         hit;
	logic         more1;
	logic         more2;

	// Handle taken in its low HANDLE_WIDTH bits.
	assign hnd_wide = 64'(req.handle);

	// Compare helpers on the latched request and the scan index.
	assign count_ext = CW1'(count_q);
	assign nxt1      = CW1'(idx_q) + CW1'(1);
	assign nxt2      = CW1'(idx_q) + CW1'(2);
	assign more1     = nxt1 < count_ext;
	assign more2     = nxt2 < count_ext;
	assign null_h    = (hnd_q == '0);
	assign full      = (count_q == CW'(CAPACITY));
	assign pos_ok    = (pos_q < 32'(count_q));
	assign hit       = (mem_rdata == hnd_q);

	// Next-state and RAM access logic.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		status_d  = status_q;
		got_d     = got_q;
		where_d   = where_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = nxt1[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				status_d = STS_OK;
				got_d    = '0;
				where_d  = '0;
				case (op_q)
					OP_APPEND: begin
						state_d = ST_RESP;
						if (null_h) begin
							status_d = STS_INVALID;
						end else if (full) begin
							status_d = STS_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = count_q[IW-1:0];
							mem_wdata = hnd_q;
							count_d   = count_q + CW'(1);
						end
					end
					OP_GET: begin
						if (!pos_ok) begin
							status_d = STS_INVALID;
							state_d  = ST_RESP;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = pos_q[IW-1:0];
							state_d   = ST_GETW;
						end
					end
					default: begin
						if (null_h) begin
							status_d = STS_INVALID;
							state_d  = ST_RESP;
						end else if (count_q == '0) begin
							status_d = STS_NOTFOUND;
							state_d  = ST_RESP;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							idx_d     = '0;
							state_d   = ST_SCAN;
						end
					end
				endcase
			end
			ST_GETW: begin
				got_d   = mem_rdata;
				state_d = ST_RESP;
			end
			ST_SCAN: begin
				// Read data belongs to idx_q; fetch the following entry meanwhile.
				if (more1) begin
					mem_re    = 1'b1;
					mem_raddr = nxt1[IW-1:0];
				end
				if (hit) begin
					if (op_q == OP_FIND) begin
						where_d = idx_q;
						state_d = ST_RESP;
					end else if (more1) begin
						state_d = ST_SHIFT;
					end else begin
						count_d = count_q - CW'(1);
						state_d = ST_RESP;
					end
				end else if (!more1) begin
					status_d = STS_NOTFOUND;
					state_d  = ST_RESP;
				end else begin
					idx_d = nxt1[IW-1:0];
				end
			end
			ST_SHIFT: begin
				// Move the entry above idx_q down by one place.
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = mem_rdata;
				if (more2) begin
					mem_re    = 1'b1;
					mem_raddr = nxt2[IW-1:0];
					idx_d     = nxt1[IW-1:0];
				end else begin
					count_d = count_q - CW'(1);
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= req.opcode;
			hnd_q <= hnd_wide[HANDLE_WIDTH-1:0];
			pos_q <= req.position;
		end
		idx_q    <= idx_d;
		status_q <= status_d;
		got_q    <= got_d;
		where_q  <= where_d;
	end

	// Response fields, cut to their port widths.
	assign got_wide   = 64'(got_q);
	assign where_wide = 64'(where_q);
	assign count_wide = 64'(count_q);

	assign idle                = (state_q == ST_IDLE);
	assign done                = (state_q == ST_RESP);
	assign rsp.status          = status_q;
	assign rsp.found_handle    = got_wide[31:0];
	assign rsp.found_position  = where_wide[3:0];
	assign rsp.entry_count     = count_wide[4:0];

	`ASSERT_PROP(a_count_cap, clk, arst_n, count_q <= CW'(CAPACITY), "fill count above capacity")
	`ASSERT_PROP(a_no_raw_clash, clk, arst_n, (mem_we && mem_re) |-> (mem_waddr != mem_raddr), "write and read hit the same entry")
	`ASSERT_PROP(a_we_states, clk, arst_n, mem_we |-> (state_q == ST_EXEC || state_q == ST_SHIFT), "RAM written outside append or shift")
	`ASSERT_PROP(a_done_held, clk, arst_n, (done && !take) |=> done, "response dropped before it was taken")
	`ASSERT_NEVER(a_start_busy, clk, arst_n, start && (state_q != ST_IDLE), "request started while busy")

endmodule

// ----- sv/ordered_handle_list.sv -----
// ----------------------------------------------------------------------------
// ordered_handle_list
// Ordered list of nonzero handles with append, get, remove and find.
// ----------------------------------------------------------------------------
// Usage: a request (opcode, handle, position) enters on req_valid/req_ready and
// each request yields exactly one response on rsp_valid/rsp_ready with a status
// and the entry count after the request. Requests are served one at a time.
// Append finishes in the execute state; get reads the RAM and waits for the
// data; find and remove scan up to a match or the end. The next request can
// be taken in the cycle after the response is loaded. Find and remove
// walk the entry RAM one entry per cycle through its single read port; remove
// then moves every later entry down by one place through the same port, so the
// scan and the shift together cover the list once. The response sits in an
// output register, so the block takes the next request while the receiver
// stalls; a second response waits in the sequencer until the register frees.
// Reset clears the entry count; the entry RAM itself is not cleared, since
// only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_handle_list #(
	parameter int CAPACITY     = ohl_pkg::CAPACITY_DEF,
	parameter int HANDLE_WIDTH = ohl_pkg::HANDLE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ohl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ohl_pkg::rsp_t rsp
);

	import ohl_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	logic                    start;
	logic                    idle;
	logic                    done;
	logic                    take;
	rsp_t                    seq_rsp;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;
	logic                    mem_we;
	logic [IW-1:0]           mem_waddr;
	logic [HANDLE_WIDTH-1:0] mem_wdata;
	logic                    mem_re;
	logic [IW-1:0]           mem_raddr;
	logic [HANDLE_WIDTH-1:0] mem_rdata;

	// Request handshake.
	assign req_ready = idle;
	assign start     = req_valid && idle;

	// Load the output register when it is empty or being drained.
	assign take = done && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= seq_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Entry storage.
	ohl_ram #(
		.WIDTH(HANDLE_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Request sequencer.
	ohl_seq #(
		.CAPACITY    (CAPACITY),
		.HANDLE_WIDTH(HANDLE_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.idle     (idle),
		.done     (done),
		.take     (take),
		.rsp      (seq_rsp),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

endmodule
